[src/delta_list_sleep_queue_macros.svh]
// Assertion macros for the delta queue RTL.
`ifndef DELTA_LIST_SLEEP_QUEUE_MACROS_SVH
`define DELTA_LIST_SLEEP_QUEUE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DLSQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dlsq check failed");

// Next-cycle implication, disabled in reset.
`define DLSQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dlsq check failed");

`endif

[src/dlsq_pkg.sv]
// Shared constants and types for the delta list sleep queue.
`default_nettype none

package dlsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int ID_W        = 8;
   localparam int MS_W        = 32;
   localparam int DELTA_W     = 29;
   localparam int KIND_W      = 2;
   localparam int WCNT_W      = $clog2(MAX_RESULTS + 1);

   // Request kinds
   localparam logic REQ_SLEEP = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   // Result kinds
   localparam logic [KIND_W-1:0] RES_ACCEPT = 2'd0;
   localparam logic [KIND_W-1:0] RES_REJECT = 2'd1;
   localparam logic [KIND_W-1:0] RES_WOKEN  = 2'd2;

   // Fixed-point reciprocal of 10: floor(x * RECIP10 / 2^35) == x / 10 for 32-bit x
   localparam logic [MS_W-1:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int              RECIP_SHIFT = 35;

   typedef struct packed {
      logic               vld;
      logic [ID_W-1:0]    id;
      logic [DELTA_W-1:0] delta;
   } entry_type;

   // Insert token travelling down the chain: search mode carries the
   // remaining ticks, shift mode carries a displaced entry.
   typedef struct packed {
      logic               vld;
      logic               shift;
      logic [ID_W-1:0]    id;
      logic [DELTA_W-1:0] val;
   } token_type;

   typedef struct packed {
      logic pop;
      logic dec;
   } cmd_type;

endpackage

`default_nettype wire

[src/dlsq_div10.sv]
// Millisecond to tick conversion: registered multiply by reciprocal of 10.
`default_nettype none

module dlsq_div10
   import dlsq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic [MS_W-1:0]    ms,
   output logic      [DELTA_W-1:0] ticks
);

   logic [2*MS_W-1:0] prod;
   logic [DELTA_W-1:0] ticks_ff;
   logic [DELTA_W-1:0] ticks_in;

   assign prod     = {{MS_W{1'b0}}, ms} * {{MS_W{1'b0}}, RECIP10};
   assign ticks_in = prod[RECIP_SHIFT +: DELTA_W];

   always_ff @(posedge clock) begin
      if (load) begin
         ticks_ff <= ticks_in;
      end
   end

   assign ticks = ticks_ff;

endmodule

`default_nettype wire

[src/dlsq_cell.sv]
// One queue slot: holds an entry, forwards the insert token, decrements on dec, shifts on pop.
`default_nettype none

module dlsq_cell
   import dlsq_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire token_type tok_in,
   input  wire entry_type right_ent,
   output entry_type      ent,
   output token_type      tok_out,
   output logic           done
);

   entry_type ent_ff;
   entry_type ent_in;
   token_type tok_ff;
   token_type tok_next_in;

   always_comb begin
      ent_in      = ent_ff;
      tok_next_in = '0;
      done        = 1'b0;
      if (cmd.pop) begin
         ent_in = right_ent;
      end else if (cmd.dec) begin
         if (ent_ff.vld && (ent_ff.delta != '0)) begin
            ent_in.delta = ent_ff.delta - DELTA_W'(1);
         end
      end else if (tok_in.vld) begin
         if (!ent_ff.vld) begin
            // empty slot: deposit
            ent_in = '{vld: 1'b1, id: tok_in.id, delta: tok_in.val};
            done   = 1'b1;
         end else if (tok_in.shift) begin
            ent_in      = '{vld: 1'b1, id: tok_in.id, delta: tok_in.val};
            tok_next_in = '{vld: 1'b1, shift: 1'b1, id: ent_ff.id, val: ent_ff.delta};
         end else if (ent_ff.delta <= tok_in.val) begin
            // pass this entry, consume its delta
            tok_next_in = '{vld: 1'b1, shift: 1'b0, id: tok_in.id,
                            val: tok_in.val - ent_ff.delta};
         end else begin
            // insert here, successor keeps only the leftover
            ent_in      = '{vld: 1'b1, id: tok_in.id, delta: tok_in.val};
            tok_next_in = '{vld: 1'b1, shift: 1'b1, id: ent_ff.id,
                            val: ent_ff.delta - tok_in.val};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff <= '0;
         tok_ff <= '0;
      end else begin
         ent_ff <= ent_in;
         tok_ff <= tok_next_in;
      end
   end

   assign ent     = ent_ff;
   assign tok_out = tok_ff;

endmodule

`default_nettype wire

[src/delta_list_sleep_queue.sv]
// Top level of the delta list sleep queue: control and the chain of slots.
//
// Usage:
//  - A transaction is taken when start is high and busy is low. req_kind
//    selects a sleep request (req_process_id, req_delay_ms) or one tick.
//  - Results leave on rsp_* for one cycle each, marked by rsp_strobe; the
//    receiver cannot stall them. rsp_last marks the final result of a
//    transaction.
//  - Sleep: the delay is converted to ticks (ms / 10) by a registered
//    multiply, then an insert token walks the slot chain one slot per cycle.
//    One result (accepted, or rejected when full) is reported once the
//    token settles or the queue is found full.
//  - Tick: ST_DEC decrements the head delta, then one zero-delta head is
//    popped and reported per cycle (the whole chain shifts left each time),
//    at most MAX_RESULTS. A tick with nothing due returns no result.
//  - busy stays high until the transaction is complete; the last result
//    sits in an output register while busy already drops.
//  - Reset (synchronous, active high) empties the queue at once.
`default_nettype none
`include "delta_list_sleep_queue_macros.svh"

module delta_list_sleep_queue
   import dlsq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_kind,
   input  wire logic [ID_W-1:0]    req_process_id,
   input  wire logic [MS_W-1:0]    req_delay_ms,
   output logic                    rsp_strobe,
   output logic      [KIND_W-1:0]  rsp_result_kind,
   output logic      [ID_W-1:0]    rsp_woken_id,
   output logic                    rsp_last
);

   // Controller states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;  // ticks ready, launch token
   localparam logic [2:0] ST_SRCH = 3'd2;  // token walking
   localparam logic [2:0] ST_DEC  = 3'd3;  // decrement head
   localparam logic [2:0] ST_WAKE = 3'd4;  // pop due heads

   logic [2:0]        state_ff, state_in;
   logic [ID_W-1:0]   pid_ff, pid_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic              rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               full;
   logic               any_done;
   logic               pop_go;
   logic               dec_go;
   logic               head_due;
   logic               next_due;
   logic               wake_cap;
   logic [DELTA_W-1:0] ticks;

   entry_type                ent_w  [QUEUE_DEPTH+1];
   token_type                tok_w  [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH-1:0]   done_w;
   logic [QUEUE_DEPTH:0]     tok_vld;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // Delay conversion, loaded on the accept edge
   dlsq_div10 u_div10 (
      .clock (clock),
      .load  (accept),
      .ms    (req_delay_ms),
      .ticks (ticks)
   );

   // Token enters slot 0 in the cycle after conversion
   assign tok_w[0] = '{vld: (state_ff == ST_DIV) && !full, shift: 1'b0,
                       id: pid_ff, val: ticks};
   assign ent_w[QUEUE_DEPTH] = '0;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         cmd_type cell_cmd;
         assign cell_cmd.pop = pop_go;
         assign cell_cmd.dec = dec_go && (i == 0);

         dlsq_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cell_cmd),
            .tok_in    (tok_w[i]),
            .right_ent (ent_w[i+1]),
            .ent       (ent_w[i]),
            .tok_out   (tok_w[i+1]),
            .done      (done_w[i])
         );
      end
      for (i = 0; i <= QUEUE_DEPTH; i++) begin : g_tokv
         assign tok_vld[i] = tok_w[i].vld;
      end
   endgenerate

   // Slot valids fill from the front, so the last slot tells full
   assign full     = ent_w[QUEUE_DEPTH-1].vld;
   assign any_done = |done_w;

   // Wake logic looks at the head and its successor
   assign head_due = ent_w[0].vld && (ent_w[0].delta == '0);
   assign next_due = ent_w[1].vld && (ent_w[1].delta == '0);
   assign wake_cap = ((wcnt_ff + WCNT_W'(1)) == WCNT_W'(MAX_RESULTS));
   assign pop_go   = (state_ff == ST_WAKE) && head_due;
   assign dec_go   = (state_ff == ST_DEC);

   always_comb begin
      state_in      = state_ff;
      pid_in        = pid_ff;
      wcnt_in       = wcnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pid_in  = req_process_id;
               wcnt_in = '0;
               state_in = (req_kind == REQ_TICK) ? ST_DEC : ST_DIV;
            end
         end
         ST_DIV: begin
            if (full) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = RES_REJECT;
               rsp_id_in     = pid_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else if (any_done) begin
               // deposited straight into slot 0
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = RES_ACCEPT;
               rsp_id_in     = pid_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (any_done) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = RES_ACCEPT;
               rsp_id_in     = pid_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DEC: begin
            state_in = ST_WAKE;
         end
         ST_WAKE: begin
            if (head_due) begin
               rsp_strobe_in = 1'b1;
               rsp_kind_in   = RES_WOKEN;
               rsp_id_in     = ent_w[0].id;
               rsp_last_in   = !next_due || wake_cap;
               wcnt_in       = wcnt_ff + WCNT_W'(1);
               if (!next_due || wake_cap) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         wcnt_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         wcnt_ff       <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff      <= pid_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_woken_id    = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;

   // Only one insert token may be in flight
   `DLSQ_ASSERT_IMP(a_one_token, clock, reset, 1'b1, $countones(tok_vld) <= 1)
   // A token always settles before running off the end of the chain
   `DLSQ_ASSERT_IMP(a_no_overrun, clock, reset, 1'b1, !tok_w[QUEUE_DEPTH].vld)
   // Wake results of one tick come back to back
   `DLSQ_ASSERT_NXT(a_wake_run, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   // A non-final result means the transaction is still in progress
   `DLSQ_ASSERT_IMP(a_busy_run, clock, reset, rsp_strobe && !rsp_last, busy)

endmodule

`default_nettype wire
